// File: design/dlr_pkg.sv
// ----------------------------------------------------------------------------
// dlr_pkg
// Shared types and constants for the DDA line rasterizer.
// ----------------------------------------------------------------------------
package dlr_pkg;

   localparam int COORD_W    = 5;
   localparam int FRAC_W     = 16;
   localparam int NUM_W      = 22;
   localparam int SLOPE_W    = 17;
   localparam int ACC_W      = 21;
   localparam int DIV_CYCLES = NUM_W / 2;
   localparam int DIV_CNT_W  = $clog2(DIV_CYCLES);
   localparam int GRID_DEF   = 32;

   typedef struct packed {
      logic [COORD_W-1:0] start_row;
      logic [COORD_W-1:0] start_col;
      logic [COORD_W-1:0] end_row;
      logic [COORD_W-1:0] end_col;
   } req_type;

   typedef struct packed {
      logic [COORD_W-1:0] pixel_row;
      logic [COORD_W-1:0] pixel_col;
      logic               last_pixel;
   } rsp_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_DIVIDE,
      ST_DRAW
   } state_type;

   typedef struct packed {
      logic load;
      logic div_step;
      logic draw;
   } cmd_type;

   typedef struct packed {
      logic last_px;
   } status_type;

endpackage

// File: design/dlr_ctrl.sv
// ----------------------------------------------------------------------------
// dlr_ctrl
// Sequencer: load, slope division, one pixel per cycle.
// ----------------------------------------------------------------------------
module dlr_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   output dlr_pkg::cmd_type    cmd,
   input  dlr_pkg::status_type status
);
   import dlr_pkg::*;

   state_type              state_ff, state_in;
   logic [DIV_CNT_W-1:0]   div_cnt_ff, div_cnt_in;
   logic                   div_done;

   localparam logic [DIV_CNT_W-1:0] DIV_LAST = DIV_CNT_W'(DIV_CYCLES - 1);

   assign div_done = (div_cnt_ff == DIV_LAST);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         div_cnt_ff <= '0;
      end else begin
         state_ff   <= state_in;
         div_cnt_ff <= div_cnt_in;
      end
   end

   // next state
   always_comb begin
      state_in   = state_ff;
      div_cnt_in = div_cnt_ff;
      case (state_ff)
         ST_IDLE: begin
            div_cnt_in = '0;
            if (start) state_in = ST_DIVIDE;
         end
         ST_DIVIDE: begin
            div_cnt_in = div_cnt_ff + 1'b1;
            if (div_done) state_in = ST_DRAW;
         end
         ST_DRAW: begin
            if (status.last_px) state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // outputs
   always_comb begin
      cmd  = '0;
      busy = 1'b1;
      case (state_ff)
         ST_IDLE: begin
            busy     = 1'b0;
            cmd.load = start;
         end
         ST_DIVIDE: begin
            cmd.div_step = 1'b1;
         end
         ST_DRAW: begin
            cmd.draw = 1'b1;
         end
         default: begin
            busy = 1'b1;
         end
      endcase
   end

endmodule

// File: design/dlr_datapath.sv
// ----------------------------------------------------------------------------
// dlr_datapath
// Endpoint setup, radix-4 restoring slope divider, DDA stepper, output reg.
// ----------------------------------------------------------------------------
module dlr_datapath #(
   parameter int GRID = dlr_pkg::GRID_DEF
) (
   input  logic                clock,
   input  logic                reset,
   input  dlr_pkg::req_type     req_data,
   input  dlr_pkg::cmd_type     cmd,
   output dlr_pkg::status_type  status,
   output logic                rsp_strobe,
   output dlr_pkg::rsp_type     rsp_data
);
   import dlr_pkg::*;

   localparam logic [COORD_W+1:0] MAX_C = (COORD_W+2)'(GRID - 1);

   function automatic logic [COORD_W-1:0] clamp(input logic [COORD_W-1:0] v);
      logic [COORD_W+1:0] w;
      w = {2'b00, v};
      return (w > MAX_C) ? MAX_C[COORD_W-1:0] : v;
   endfunction

   // one restoring division step: {quotient bit, remainder}
   function automatic logic [COORD_W:0] dstep(input logic [COORD_W-1:0] r,
                                              input logic               b,
                                              input logic [COORD_W-1:0] d);
      logic [COORD_W:0] t;
      logic [COORD_W:0] dd;
      t  = {r, b};
      dd = {1'b0, d};
      if (t >= dd) return {1'b1, COORD_W'(t - dd)};
      else         return {1'b0, t[COORD_W-1:0]};
   endfunction

   // setup
   logic [COORD_W-1:0] r0, c0, r1, c1, drow, dcol, dmaj, dmin;
   logic               row_major;

   always_comb begin
      r0        = clamp(req_data.start_row);
      c0        = clamp(req_data.start_col);
      r1        = clamp(req_data.end_row);
      c1        = clamp(req_data.end_col);
      drow      = (r0 > r1) ? r0 - r1 : r1 - r0;
      dcol      = (c0 > c1) ? c0 - c1 : c1 - c0;
      row_major = drow > dcol;
      dmaj      = row_major ? drow : dcol;
      dmin      = row_major ? dcol : drow;
   end

   logic [COORD_W-1:0] maj_ff, maj_in, min0_ff, min0_in;
   logic [COORD_W-1:0] dmaj_ff, dmaj_in, left_ff, left_in, rem_ff, rem_in;
   logic               row_major_ff, row_major_in, maj_up_ff, maj_up_in;
   logic               min_up_ff, min_up_in;
   logic [NUM_W-1:0]   num_ff, num_in;
   logic [ACC_W-1:0]   acc_ff, acc_in;
   logic               rsp_valid_ff, rsp_valid_in;
   rsp_type            rsp_ff, rsp_in;

   logic [COORD_W:0]   s1, s2;
   logic [COORD_W-1:0] off, mnr, maj_out;

   assign s1  = dstep(rem_ff, num_ff[NUM_W-1], dmaj_ff);
   assign s2  = dstep(s1[COORD_W-1:0], num_ff[NUM_W-2], dmaj_ff);
   // accumulator carries the rounding half, so the integer part is the offset
   assign off = acc_ff[ACC_W-1:FRAC_W];
   assign mnr = min_up_ff ? min0_ff + off : min0_ff - off;
   assign maj_out = maj_ff;

   assign status.last_px = (left_ff == '0);

   always_comb begin
      maj_in       = maj_ff;
      min0_in      = min0_ff;
      dmaj_in      = dmaj_ff;
      left_in      = left_ff;
      rem_in       = rem_ff;
      row_major_in = row_major_ff;
      maj_up_in    = maj_up_ff;
      min_up_in    = min_up_ff;
      num_in       = num_ff;
      acc_in       = acc_ff;
      rsp_valid_in = 1'b0;
      rsp_in       = rsp_ff;

      if (cmd.load) begin
         row_major_in = row_major;
         maj_in       = row_major ? r0 : c0;
         min0_in      = row_major ? c0 : r0;
         maj_up_in    = row_major ? (r1 >= r0) : (c1 >= c0);
         min_up_in    = row_major ? (c1 >= c0) : (r1 >= r0);
         dmaj_in      = dmaj;
         left_in      = dmaj;
         rem_in       = '0;
         num_in       = {1'b0, dmin, {FRAC_W{1'b0}}} + NUM_W'(dmaj >> 1);
         acc_in       = ACC_W'(1) << (FRAC_W - 1);
      end

      if (cmd.div_step) begin
         num_in = {num_ff[NUM_W-3:0], s1[COORD_W], s2[COORD_W]};
         rem_in = s2[COORD_W-1:0];
      end

      if (cmd.draw) begin
         rsp_valid_in        = 1'b1;
         rsp_in.pixel_row    = row_major_ff ? maj_out : mnr;
         rsp_in.pixel_col    = row_major_ff ? mnr : maj_out;
         rsp_in.last_pixel   = status.last_px;
         maj_in              = maj_up_ff ? maj_ff + 1'b1 : maj_ff - 1'b1;
         acc_in              = acc_ff + ACC_W'(num_ff[SLOPE_W-1:0]);
         left_in             = left_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      maj_ff       <= maj_in;
      min0_ff      <= min0_in;
      dmaj_ff      <= dmaj_in;
      left_ff      <= left_in;
      rem_ff       <= rem_in;
      row_major_ff <= row_major_in;
      maj_up_ff    <= maj_up_in;
      min_up_ff    <= min_up_in;
      num_ff       <= num_in;
      acc_ff       <= acc_in;
      rsp_ff       <= rsp_in;
   end

   assign rsp_strobe = rsp_valid_ff;
   assign rsp_data   = rsp_ff;

endmodule

// File: design/dda_line_rasterizer_unit.sv
// ----------------------------------------------------------------------------
// dda_line_rasterizer_unit
// DDA line rasterizer: one segment in, one pixel transaction per grid step out.
// ----------------------------------------------------------------------------
// Usage:
//  - Request: drive req_data with the segment end points and raise start; the
//    transaction is taken on the clock edge where start is high and busy low.
//  - Coordinates above GRID-1 are saturated to GRID-1 before use.
//  - Response: one pixel per cycle on rsp_data, qualified by rsp_strobe for
//    exactly one cycle; last_pixel flags the final pixel. There is no
//    backpressure: the receiver must take every pixel as it appears.
//  - Timing: after the edge that takes a segment with major delta D, busy
//    stays high through the slope division and then D+1 draw steps. The
//    division is a radix-4 restoring division of the slope, two quotient
//    bits a cycle over a 22-bit dividend; then one pixel per cycle.
//  - The first pixel shows on rsp_strobe once the division is done; the last
//    pixel shows in the first cycle with busy low, and a new segment may be
//    accepted in that same cycle.
//  - Reset (synchronous, active high) returns the sequencer to idle and clears
//    the response strobe; any segment in flight is dropped.
// ----------------------------------------------------------------------------
module dda_line_rasterizer_unit #(
   parameter int GRID = dlr_pkg::GRID_DEF
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  dlr_pkg::req_type req_data,
   output logic             rsp_strobe,
   output dlr_pkg::rsp_type rsp_data
);
   import dlr_pkg::*;

   cmd_type    cmd;      // sequencer commands to the datapath
   status_type status;   // pixel counter status back to the sequencer

   // Sequencer: idle -> slope divide -> draw
   dlr_ctrl u_ctrl (
      .clock  (clock),
      .reset  (reset),
      .start  (start),
      .busy   (busy),
      .cmd    (cmd),
      .status (status)
   );

   // Setup, divider, DDA stepper and registered response
   dlr_datapath #(
      .GRID (GRID)
   ) u_datapath (
      .clock      (clock),
      .reset      (reset),
      .req_data   (req_data),
      .cmd        (cmd),
      .status     (status),
      .rsp_strobe (rsp_strobe),
      .rsp_data   (rsp_data)
   );

endmodule

// File: design/dlr_checker.sv
// ----------------------------------------------------------------------------
// dlr_checker
// Port-level checks on request/response sequencing of the rasterizer.
// ----------------------------------------------------------------------------
module dlr_checker (
   input logic             clock,
   input logic             reset,
   input logic             start,
   input logic             busy,
   input dlr_pkg::rsp_type rsp_data,
   input logic             rsp_strobe
);
   import dlr_pkg::*;

   // accepted request occupies the unit
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("busy not raised after request");

   // no pixel right after a request is taken
   a_accept_quiet: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> !rsp_strobe)
      else $error("pixel right after request");

   // pixels of one segment come back to back
   a_burst: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && !rsp_data.last_pixel) |=> rsp_strobe)
      else $error("gap inside a segment");

   // nothing follows the last pixel directly
   a_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_data.last_pixel) |=> !rsp_strobe)
      else $error("pixel after last pixel");

   // pixels only while busy or just after it drops
   a_strobe_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> (busy || $fell(busy)))
      else $error("pixel while idle");

endmodule

bind dda_line_rasterizer_unit dlr_checker u_dlr_checker (
   .clock      (clock),
   .reset      (reset),
   .start      (start),
   .busy       (busy),
   .rsp_data   (rsp_data),
   .rsp_strobe (rsp_strobe)
);
